@@ design/idba_pkg.sv @@
// Shared constants, command codes and helpers of the bitmap ID allocator.
// No dependencies; used by idba_map and id_bitmap_allocator.
package idba_pkg;

    localparam int WORD_W        = 64;  // bitmap bits held in one memory row
    localparam int BIT_W         = 6;   // bit index within a row
    localparam int POOL_SIZE_DEF = 1024;
    localparam int ID_W          = 32;
    localparam int COUNT_W       = 11;
    localparam int CMD_W         = 2;
    localparam int IN_TDATA_W    = 40;  // cmd + req_id, padded to bytes
    localparam int OUT_TDATA_W   = 40;  // ok + granted_id, padded to bytes
    localparam int CFG_IDX_W     = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ID_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_COUNT = 2'd1;

    localparam logic [COUNT_W-1:0] ID_COUNT_RST = 11'd1024;

    // Index of the lowest set bit of a row; zero when no bit is set.
    function automatic logic [BIT_W-1:0] low_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ design/idba_map.sv @@
// Used-bitmap storage of the ID allocator: one 64-bit row per address,
// one write port and one registered read port. Depends on idba_pkg.
module idba_map #(
    parameter int  POOL_SIZE = idba_pkg::POOL_SIZE_DEF,
    localparam int MAP_WORDS = (POOL_SIZE + idba_pkg::WORD_W - 1) / idba_pkg::WORD_W,
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [WA_W-1:0]                  i_waddr,
    input  logic [idba_pkg::WORD_W-1:0]      i_wdata,
    input  logic [WA_W-1:0]                  i_raddr,
    output logic [idba_pkg::WORD_W-1:0]      o_rdata
);
    logic [idba_pkg::WORD_W-1:0] r_mem [MAP_WORDS];
    logic [idba_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/id_bitmap_allocator.sv @@
// Bitmap ID allocator on idba_map and idba_pkg: allocate, reserve and free IDs.
// Allocate: rows are read and checked in order from row 0 (one 64-bit row checked
// per cycle); the first free bit found is set by a row write, then the result follows.
// Reserve and free: range check, row read, row write, result.
// One request at a time; the next is taken the cycle after the result is loaded.
// Synchronous active-low reset starts a pass that clears every row of the bitmap.
module id_bitmap_allocator #(
    parameter int POOL_SIZE = idba_pkg::POOL_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [idba_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // cmd[1:0], req_id[33:2]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [idba_pkg::OUT_TDATA_W-1:0]    o_m_tdata,   // ok[0], granted_id[32:1]
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [idba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [idba_pkg::ID_W-1:0]           i_cfg_data
);
    localparam int MAP_WORDS = (POOL_SIZE + idba_pkg::WORD_W - 1) / idba_pkg::WORD_W;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFF_W     = WA_W + idba_pkg::BIT_W;
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int ID_W      = idba_pkg::ID_W;
    localparam int WORD_W    = idba_pkg::WORD_W;
    localparam int BIT_W     = idba_pkg::BIT_W;
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);
    localparam logic [ID_W-1:0] POOL_ID   = ID_W'(POOL_SIZE);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_RNG, S_RD, S_MOD, S_SCAN, S_SET, S_DONE
    } t_state;

    t_state                     r_state, n_state;
    logic [WA_W-1:0]            r_clr_addr, n_clr_addr;
    logic [WA_W-1:0]            r_scan_addr, n_scan_addr;
    logic                       r_chk_vld, n_chk_vld;
    logic [WA_W-1:0]            r_chk_word, n_chk_word;
    logic [idba_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [ID_W-1:0]            r_req, n_req;
    logic [OFF_W-1:0]           r_off, n_off;
    logic [WORD_W-1:0]          r_word, n_word;
    logic                       r_res_ok, n_res_ok;
    logic [ID_W-1:0]            r_res_id, n_res_id;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_ok, n_out_ok;
    logic [ID_W-1:0]            r_out_id, n_out_id;
    logic [ID_W-1:0]            r_id_base;
    logic [idba_pkg::COUNT_W-1:0] r_id_count;

    logic                       map_we;
    logic [WA_W-1:0]            map_waddr;
    logic [WORD_W-1:0]          map_wdata;
    logic [WA_W-1:0]            map_raddr;
    logic [WORD_W-1:0]          map_rdata;

    logic [ID_W-1:0]            eff32;
    logic [CNT_W-1:0]           eff;
    logic [ID_W:0]              diff;
    logic [ID_W-1:0]            row_lo;
    logic [ID_W-1:0]            row_rem;
    logic [WORD_W-1:0]          row_mask;
    logic [WORD_W-1:0]          row_free;
    logic [WORD_W-1:0]          bit_sel;
    logic                       in_acc;

    idba_map #(
        .POOL_SIZE (POOL_SIZE)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {7'd0, r_out_id, r_out_ok};

    // A count above the pool size acts as the pool size.
    assign eff32 = ({21'd0, r_id_count} > POOL_ID) ? POOL_ID : {21'd0, r_id_count};
    assign eff   = eff32[CNT_W-1:0];
    assign diff  = {1'b0, r_req} - {1'b0, r_id_base};

    // Bits of the checked row that lie at or above the effective count count as used.
    assign row_lo   = ID_W'({r_chk_word, {BIT_W{1'b0}}});
    assign row_rem  = {{(ID_W - CNT_W){1'b0}}, eff} - row_lo;
    assign row_mask = (row_rem >= ID_W'(WORD_W)) ? {WORD_W{1'b1}}
                    : ((WORD_W'(1) << row_rem[BIT_W-1:0]) - WORD_W'(1));
    assign row_free = ~map_rdata & row_mask;
    assign bit_sel  = WORD_W'(1) << r_off[BIT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_scan_addr = r_scan_addr;
        n_chk_vld   = 1'b0;
        n_chk_word  = r_chk_word;
        n_cmd       = r_cmd;
        n_req       = r_req;
        n_off       = r_off;
        n_word      = r_word;
        n_res_ok    = r_res_ok;
        n_res_id    = r_res_id;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_ok    = r_out_ok;
        n_out_id    = r_out_id;
        map_we      = 1'b0;
        map_waddr   = r_off[OFF_W-1:BIT_W];
        map_wdata   = '0;
        map_raddr   = r_off[OFF_W-1:BIT_W];

        case (r_state)
            S_CLR: begin
                map_we     = 1'b1;
                map_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + WA_W'(1);
                if (r_clr_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd       = i_s_tdata[1:0];
                    n_req       = i_s_tdata[33:2];
                    n_res_ok    = 1'b0;
                    n_res_id    = '0;
                    n_scan_addr = '0;
                    case (i_s_tdata[1:0])
                        idba_pkg::CMD_ALLOC:   n_state = S_SCAN;
                        idba_pkg::CMD_RESERVE: n_state = S_RNG;
                        idba_pkg::CMD_FREE:    n_state = S_RNG;
                        default:               n_state = S_DONE;
                    endcase
                end
            end
            S_RNG: begin
                // In range when req_id >= base and the difference is below the count.
                n_off = diff[OFF_W-1:0];
                if (!diff[ID_W] && (diff[ID_W-1:0] < eff32)) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                map_we    = 1'b1;
                map_wdata = (r_cmd == idba_pkg::CMD_RESERVE) ? (map_rdata | bit_sel)
                                                             : (map_rdata & ~bit_sel);
                n_res_ok  = 1'b1;
                n_state   = S_DONE;
            end
            S_SCAN: begin
                // Rows are read back to back; each is checked in the cycle after its read.
                map_raddr   = r_scan_addr;
                n_chk_vld   = 1'b1;
                n_chk_word  = r_scan_addr;
                n_scan_addr = (r_scan_addr == LAST_WORD) ? r_scan_addr
                                                         : r_scan_addr + WA_W'(1);
                if (r_chk_vld) begin
                    if (row_lo >= eff32) begin
                        n_state = S_DONE;
                    end else if (row_free != '0) begin
                        n_off   = {r_chk_word, idba_pkg::low_set(row_free)};
                        n_word  = map_rdata;
                        n_state = S_SET;
                    end else if (r_chk_word == LAST_WORD) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SET: begin
                map_we    = 1'b1;
                map_wdata = r_word | bit_sel;
                n_res_ok  = 1'b1;
                n_res_id  = r_id_base + ID_W'(r_off);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_id    = r_res_id;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_id_base   <= '0;
            r_id_count  <= idba_pkg::ID_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == idba_pkg::REG_ID_BASE) begin
                    r_id_base <= i_cfg_data;
                end else if (i_cfg_index == idba_pkg::REG_ID_COUNT) begin
                    r_id_count <= i_cfg_data[idba_pkg::COUNT_W-1:0];
                end
            end
        end
        r_scan_addr <= n_scan_addr;
        r_chk_word  <= n_chk_word;
        r_cmd       <= n_cmd;
        r_req       <= n_req;
        r_off       <= n_off;
        r_word      <= n_word;
        r_res_ok    <= n_res_ok;
        r_res_id    <= n_res_id;
        r_out_ok    <= n_out_ok;
        r_out_id    <= n_out_id;
    end

    // A failed request never reports a nonzero ID.
    a_fail_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[32:1] == '0)
        else $error("failed request carries a nonzero ID");

    // The bitmap is only written by the clearing pass or a request in flight.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) || (r_state == S_DONE) |-> !map_we)
        else $error("bitmap written outside of a request");

    // The checked row is always the one read in the previous scan cycle.
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_chk_vld && (r_chk_word != LAST_WORD)
        |-> r_scan_addr == r_chk_word + WA_W'(1))
        else $error("scan pipeline out of step");

    // A result is loaded only when the output register is free or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid)
        else $error("pending result dropped");

endmodule
